### rtl/mrfc_pkg.sv
package mrfc_pkg;

    localparam int FRAME_BYTES = 19;
    localparam int STORE_AW    = $clog2(FRAME_BYTES);
    localparam int VALUE_W     = 30;
    localparam int NUM_VALUES  = 4;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [7:0]  COUNT_MAX = 8'hFF;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_LEN = 2'd1,
        ST_CRC = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        MODE_STATUS = 3'd0,
        MODE_ONE3   = 3'd1,
        MODE_THREE3 = 3'd2,
        MODE_FOUR3  = 3'd3,
        MODE_FOUR4  = 3'd4
    } t_mode;

    typedef logic [VALUE_W-1:0] t_value;

    // Expected frame length per kind; undefined kinds never match.
    function automatic logic [7:0] need_len(input logic [2:0] mode);
        logic [7:0] n;
        case (mode)
            MODE_STATUS: n = 8'd4;
            MODE_ONE3:   n = 8'd6;
            MODE_THREE3: n = 8'd12;
            MODE_FOUR3:  n = 8'd15;
            MODE_FOUR4:  n = 8'd19;
            default:     n = 8'd0;
        endcase
        return n;
    endfunction

    // One byte of CRC-16/Modbus, LSB first.
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // 3-byte field: masked top byte first, then the other two swapped.
    function automatic t_value take3(input logic [7:0] b0, input logic [7:0] b1,
                                     input logic [7:0] b2);
        return {{(VALUE_W-22){1'b0}}, b0[5:0], b2, b1};
    endfunction

    // 4-byte counter: bytes swapped within each word, high word masked.
    function automatic t_value take4(input logic [7:0] b0, input logic [7:0] b1,
                                     input logic [7:0] b2, input logic [7:0] b3);
        return {b1[5:0], b0, b3, b2};
    endfunction

endpackage

### rtl/mrfc_if.sv
interface mrfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic [2:0] mode;
    logic       last_byte;

    modport source(output valid, output rx_byte, output mode, output last_byte, input ready);
    modport sink(input valid, input rx_byte, input mode, input last_byte, output ready);
endinterface

interface mrfc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [1:0]  value_index;
    logic [29:0] value;
    logic        last_value;

    modport source(output valid, output status, output value_index, output value,
                   output last_value, input ready);
    modport sink(input valid, input status, input value_index, input value,
                 input last_value, output ready);
endinterface

### rtl/meter_response_frame_checker.sv
// Meter reply frame checker.
// i_in carries one reply byte per beat with its frame kind and a last-byte
// flag; o_out carries the results of a frame: one error beat (wrong length
// takes precedence over CRC mismatch) or one beat per decoded value, in frame
// order, the final one flagged by last_value.
// Throughput: one byte per cycle while no last byte waits, set by the
// combinational unrolled CRC byte step between the input register and the
// frame state. The first result of a frame is registered: its last byte
// passes the input register, then the result register, before it shows on
// o_out; further values follow one per cycle while the receiver is ready.
// A frame's results are snapshotted, so the next frame's bytes keep flowing
// while they drain. Only the last byte of a frame waits in the input register
// while the previous frame still has results to deliver.
// Reset (synchronous, active low) empties both registers, clears the byte
// count and reloads the CRC with all ones. No clearing pass is needed.
// When the receiver stalls, the current result holds on o_out and bytes are
// still taken until a second frame is ready to report.
module meter_response_frame_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mrfc_in_if.sink           i_in,
    mrfc_out_if.source        o_out
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic [2:0] r_in_mode;
    logic       r_in_last;

    // frame state
    logic [15:0] r_crc;
    logic [7:0]  r_cnt;
    logic [7:0]  r_prev1;
    logic [7:0]  r_prev2;
    logic [7:0]  r_store [mrfc_pkg::FRAME_BYTES];

    // result snapshot
    logic                  r_job_valid;
    mrfc_pkg::t_status     r_job_status;
    logic [1:0]            r_job_idx;
    logic [1:0]            r_job_last;
    mrfc_pkg::t_value      r_job_val [mrfc_pkg::NUM_VALUES];

    logic              w_out_fire;
    logic              w_out_done;
    logic              w_job_free;
    logic              w_advance;
    logic              w_load;
    logic [7:0]        w_len;
    logic [7:0]        w_need;
    logic              w_fold;
    logic              w_store_wr;
    logic [15:0]       w_crc_next;
    logic [15:0]       w_got;
    mrfc_pkg::t_status w_status;
    logic [1:0]        w_last;
    mrfc_pkg::t_value  w_vals [mrfc_pkg::NUM_VALUES];

    // Handshake: a last byte moves on only once the previous frame's
    // results are gone (or leave in this cycle).
    assign w_out_fire = r_job_valid && o_out.ready;
    assign w_out_done = w_out_fire && (r_job_idx == r_job_last);
    assign w_job_free = !r_job_valid || w_out_done;
    assign w_advance  = r_in_valid && (!r_in_last || w_job_free);
    assign w_load     = w_advance && r_in_last;
    assign i_in.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.rx_byte;
            r_in_mode <= i_in.mode;
            r_in_last <= i_in.last_byte;
        end
    end

    // The CRC trails the stream by two bytes, so fold the byte taken two
    // beats ago; the last two bytes of the frame are then the expected CRC.
    assign w_len      = (r_cnt == mrfc_pkg::COUNT_MAX) ? r_cnt : r_cnt + 8'd1;
    assign w_fold     = (r_cnt >= 8'd2) && (r_cnt < 8'(mrfc_pkg::FRAME_BYTES + 2));
    assign w_store_wr = r_cnt < 8'(mrfc_pkg::FRAME_BYTES);
    assign w_crc_next = w_fold ? mrfc_pkg::crc_fold(r_crc, r_prev2) : r_crc;
    assign w_got      = {r_in_byte, r_prev1};
    assign w_need     = mrfc_pkg::need_len(r_in_mode);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_crc <= mrfc_pkg::CRC_INIT;
        end else if (w_advance) begin
            r_cnt <= r_in_last ? 8'd0 : w_len;
            r_crc <= r_in_last ? mrfc_pkg::CRC_INIT : w_crc_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_prev2 <= r_prev1;
            r_prev1 <= r_in_byte;
            if (w_store_wr) begin
                r_store[r_cnt[mrfc_pkg::STORE_AW-1:0]] <= r_in_byte;
            end
        end
    end

    // Decode the whole frame from fixed store positions; the current byte is
    // the CRC high byte and never part of a field.
    always_comb begin
        w_status = mrfc_pkg::ST_OK;
        w_last   = 2'd0;
        for (int k = 0; k < mrfc_pkg::NUM_VALUES; k++) begin
            w_vals[k] = '0;
        end
        if (w_len != w_need) begin
            w_status = mrfc_pkg::ST_LEN;
        end else if (w_got != w_crc_next) begin
            w_status = mrfc_pkg::ST_CRC;
        end else begin
            case (r_in_mode)
                mrfc_pkg::MODE_STATUS: begin
                    w_vals[0] = {{(mrfc_pkg::VALUE_W-4){1'b0}}, r_store[1][3:0]};
                end
                mrfc_pkg::MODE_ONE3: begin
                    w_vals[0] = mrfc_pkg::take3(r_store[1], r_store[2], r_store[3]);
                end
                mrfc_pkg::MODE_THREE3: begin
                    w_vals[0] = mrfc_pkg::take3(r_store[1], r_store[2], r_store[3]);
                    w_vals[1] = mrfc_pkg::take3(r_store[4], r_store[5], r_store[6]);
                    w_vals[2] = mrfc_pkg::take3(r_store[7], r_store[8], r_store[9]);
                    w_last    = 2'd2;
                end
                mrfc_pkg::MODE_FOUR3: begin
                    w_vals[0] = mrfc_pkg::take3(r_store[1], r_store[2], r_store[3]);
                    w_vals[1] = mrfc_pkg::take3(r_store[4], r_store[5], r_store[6]);
                    w_vals[2] = mrfc_pkg::take3(r_store[7], r_store[8], r_store[9]);
                    w_vals[3] = mrfc_pkg::take3(r_store[10], r_store[11], r_store[12]);
                    w_last    = 2'd3;
                end
                mrfc_pkg::MODE_FOUR4: begin
                    w_vals[0] = mrfc_pkg::take4(r_store[1], r_store[2], r_store[3],
                                                r_store[4]);
                    w_vals[1] = mrfc_pkg::take4(r_store[5], r_store[6], r_store[7],
                                                r_store[8]);
                    w_vals[2] = mrfc_pkg::take4(r_store[9], r_store[10], r_store[11],
                                                r_store[12]);
                    w_vals[3] = mrfc_pkg::take4(r_store[13], r_store[14], r_store[15],
                                                r_store[16]);
                    w_last    = 2'd3;
                end
                default: begin
                    w_status = mrfc_pkg::ST_LEN;
                end
            endcase
        end
    end

    // Result snapshot: load on a last byte, advance one value per beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_job_idx   <= '0;
        end else if (w_load) begin
            r_job_valid <= 1'b1;
            r_job_idx   <= '0;
        end else if (w_out_done) begin
            r_job_valid <= 1'b0;
        end else if (w_out_fire) begin
            r_job_idx <= r_job_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_job_status <= w_status;
            r_job_last   <= w_last;
            for (int k = 0; k < mrfc_pkg::NUM_VALUES; k++) begin
                r_job_val[k] <= w_vals[k];
            end
        end else if (w_out_fire) begin
            for (int k = 0; k < mrfc_pkg::NUM_VALUES - 1; k++) begin
                r_job_val[k] <= r_job_val[k+1];
            end
        end
    end

    assign o_out.valid       = r_job_valid;
    assign o_out.status      = r_job_status;
    assign o_out.value_index = r_job_idx;
    assign o_out.value       = r_job_val[0];
    assign o_out.last_value  = (r_job_idx == r_job_last);

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid |-> (r_job_idx <= r_job_last))
        else $error("value index ran past the last value of the frame");

    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_job_valid && (r_job_status != mrfc_pkg::ST_OK)) |->
        ((r_job_last == 2'd0) && (r_job_val[0] == '0)))
        else $error("error result is not a single zero beat");

    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_fire && !w_out_done) |=>
        (r_job_valid && (r_job_idx == 2'($past(r_job_idx) + 2'd1))))
        else $error("value index did not advance by one");

    a_count_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> ((r_cnt == 8'd0) && (r_crc == mrfc_pkg::CRC_INIT)))
        else $error("frame state not restarted after last byte");

    a_last_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_last && !w_job_free) |=> r_in_valid)
        else $error("last byte dropped while results were pending");

endmodule

### tb/sv/meter_response_frame_checker_tb.sv
module meter_response_frame_checker_tb;

    import mrfc_pkg::*;

    // Frame kinds without a defined length; the block must call them wrong length.
    localparam logic [2:0] MODE_SPARE5 = 3'd5;
    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;

    localparam int RANDOM_BYTES   = 220;
    localparam int RANDOM_RESULTS = 60;
    localparam int MAX_GAP        = 8;
    localparam int HOLD_OFF       = 400;   // long receiver stall, in cycles
    localparam int TAIL_CYCLES    = 20;    // run-out after the drain, for stray results
    localparam int CYCLE_LIMIT    = 200000;
    localparam int NUM_ROWS       = 24;

    typedef enum {FILL_ZERO, FILL_ONES, FILL_RAND} t_fill;

    typedef struct packed {
        t_status    status;
        logic [1:0] slot;
        t_value     value;
        logic       last_value;
    } t_result;

    typedef struct {
        logic [7:0] data;
        logic [2:0] kind;
        logic       tail;
        bit         typed;     // expectation written in the table, not predicted
        t_result    want;
    } t_rx_beat;

    typedef struct {
        logic [2:0] kind;
        int         nbytes;
        t_fill      fill;
        bit         crc_good;
        bit         typed;
        t_status    want_status;
        t_value     want_value;
    } t_frame_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mrfc_in_if  byte_bus ();
    mrfc_out_if result_bus ();

    meter_response_frame_checker u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_bus),
        .o_out   (result_bus)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Directed frames. Rows with typed set carry their single result; the
    // others go through the decoder below.
    t_frame_row frame_table [NUM_ROWS] = '{
        '{MODE_STATUS, 4,   FILL_ZERO, 1'b1, 1'b1, ST_OK,  30'h0},
        '{MODE_STATUS, 4,   FILL_ONES, 1'b1, 1'b1, ST_OK,  30'hF},
        '{MODE_ONE3,   6,   FILL_ZERO, 1'b1, 1'b1, ST_OK,  30'h0},
        '{MODE_ONE3,   6,   FILL_ONES, 1'b1, 1'b1, ST_OK,  30'h3FFFFF},
        '{MODE_THREE3, 12,  FILL_RAND, 1'b1, 1'b0, ST_OK,  30'h0},
        '{MODE_FOUR3,  15,  FILL_ONES, 1'b1, 1'b0, ST_OK,  30'h0},
        '{MODE_FOUR4,  19,  FILL_ONES, 1'b1, 1'b0, ST_OK,  30'h0},
        '{MODE_FOUR4,  19,  FILL_ZERO, 1'b1, 1'b0, ST_OK,  30'h0},
        '{MODE_FOUR3,  15,  FILL_RAND, 1'b1, 1'b0, ST_OK,  30'h0},
        '{MODE_THREE3, 12,  FILL_ZERO, 1'b1, 1'b0, ST_OK,  30'h0},
        '{MODE_ONE3,   6,   FILL_RAND, 1'b0, 1'b1, ST_CRC, 30'h0},
        '{MODE_FOUR4,  19,  FILL_RAND, 1'b0, 1'b1, ST_CRC, 30'h0},
        '{MODE_STATUS, 4,   FILL_RAND, 1'b0, 1'b1, ST_CRC, 30'h0},
        '{MODE_STATUS, 5,   FILL_RAND, 1'b1, 1'b1, ST_LEN, 30'h0},
        '{MODE_FOUR4,  18,  FILL_RAND, 1'b1, 1'b1, ST_LEN, 30'h0},
        '{MODE_THREE3, 1,   FILL_ONES, 1'b1, 1'b1, ST_LEN, 30'h0},
        '{MODE_ONE3,   12,  FILL_RAND, 1'b0, 1'b1, ST_LEN, 30'h0},
        '{MODE_SPARE5, 4,   FILL_RAND, 1'b1, 1'b1, ST_LEN, 30'h0},
        '{MODE_SPARE6, 19,  FILL_RAND, 1'b1, 1'b1, ST_LEN, 30'h0},
        '{MODE_SPARE7, 6,   FILL_RAND, 1'b1, 1'b1, ST_LEN, 30'h0},
        '{MODE_FOUR4,  20,  FILL_RAND, 1'b1, 1'b1, ST_LEN, 30'h0},
        '{MODE_FOUR4,  300, FILL_RAND, 1'b1, 1'b1, ST_LEN, 30'h0},
        '{MODE_FOUR4,  19,  FILL_RAND, 1'b1, 1'b0, ST_OK,  30'h0},
        '{MODE_STATUS, 4,   FILL_RAND, 1'b1, 1'b0, ST_OK,  30'h0}
    };

    t_rx_beat    rx_beats [$];
    t_result     pending_results [$];
    t_result     frame_results [$];

    // Decoder state: running CRC, byte count and the bytes of the current frame.
    logic [15:0] model_crc;
    logic [7:0]  model_count;
    logic [7:0]  model_bytes [FRAME_BYTES];

    int unsigned results_seen;
    int unsigned mismatches;
    int unsigned cycle_count;

    function automatic int frame_len(input logic [2:0] kind);
        case (kind)
            MODE_STATUS: return 4;
            MODE_ONE3:   return 6;
            MODE_THREE3: return 12;
            MODE_FOUR3:  return 15;
            MODE_FOUR4:  return 19;
            default:     return 0;
        endcase
    endfunction

    function automatic int values_in(input logic [2:0] kind);
        case (kind)
            MODE_STATUS, MODE_ONE3: return 1;
            MODE_THREE3:            return 3;
            default:                return 4;
        endcase
    endfunction

    // Bit-serial CRC-16/Modbus: feed data LSB first, xor the reflected poly on feedback.
    function automatic logic [15:0] modbus_crc_step(input logic [15:0] crc, input logic [7:0] d);
        logic fb;
        for (int k = 0; k < 8; k++) begin
            fb  = crc[0] ^ d[k];
            crc = crc >> 1;
            if (fb) begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

    function automatic t_value reading_at(input int p);
        return (t_value'(model_bytes[p] & 8'h3F) << 16) | (t_value'(model_bytes[p + 2]) << 8) |
               t_value'(model_bytes[p + 1]);
    endfunction

    function automatic t_value counter_at(input int p);
        return (t_value'(model_bytes[p + 1] & 8'h3F) << 24) | (t_value'(model_bytes[p]) << 16) |
               (t_value'(model_bytes[p + 3]) << 8) | t_value'(model_bytes[p + 2]);
    endfunction

    // Fold one accepted byte into the frame state; on the final byte leave the
    // results of the frame in frame_results.
    function automatic void decode_beat(input logic [7:0] d, input logic [2:0] kind,
                                        input logic tail);
        int      pos;
        int      len;
        int      nvals;
        t_result r;
        pos = model_count;
        frame_results.delete();
        // The CRC lags two bytes behind so that the trailing pair stays out of it.
        if (pos >= 2 && pos - 2 < FRAME_BYTES) begin
            model_crc = modbus_crc_step(model_crc, model_bytes[pos - 2]);
        end
        if (pos < FRAME_BYTES) begin
            model_bytes[pos] = d;
        end
        if (model_count != COUNT_MAX) begin
            model_count = model_count + 8'd1;
        end
        if (!tail) begin
            return;
        end
        len         = model_count;
        model_count = '0;
        r           = '{ST_OK, 2'd0, '0, 1'b1};
        if (len != frame_len(kind)) begin
            r.status = ST_LEN;
        end else if ({model_bytes[len - 1], model_bytes[len - 2]} != model_crc) begin
            r.status = ST_CRC;
        end
        model_crc = CRC_INIT;
        if (r.status != ST_OK) begin
            frame_results.push_back(r);
        end else if (kind == MODE_STATUS) begin
            r.value = t_value'(model_bytes[1] & 8'h0F);
            frame_results.push_back(r);
        end else begin
            nvals = values_in(kind);
            for (int i = 0; i < nvals; i++) begin
                r.slot       = 2'(i);
                r.value      = (kind == MODE_FOUR4) ? counter_at(1 + 4 * i) : reading_at(1 + 3 * i);
                r.last_value = (i == nvals - 1);
                frame_results.push_back(r);
            end
        end
    endfunction

    // Build one frame as beats. Frames of three bytes or more end in the CRC
    // of the rest, so only the length is wrong where the length is wrong;
    // a bad CRC flips one bit of the trailing pair.
    function automatic void queue_frame(input logic [2:0] kind, input int nbytes,
                                        input t_fill fill, input bit crc_good,
                                        input bit typed, input t_result want);
        logic [7:0]  body [$];
        logic [15:0] crc;
        t_rx_beat    b;
        crc = CRC_INIT;
        for (int k = 0; k < nbytes; k++) begin
            case (fill)
                FILL_ZERO: body.push_back(8'h00);
                FILL_ONES: body.push_back(8'hFF);
                default:   body.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        if (nbytes >= 3) begin
            for (int k = 0; k < nbytes - 2; k++) begin
                crc = modbus_crc_step(crc, body[k]);
            end
            body[nbytes - 2] = crc[7:0];
            body[nbytes - 1] = crc[15:8];
            if (!crc_good) begin
                body[nbytes - 1 - $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
            end
        end
        for (int k = 0; k < nbytes; k++) begin
            b.data  = body[k];
            b.tail  = (k == nbytes - 1);
            // The kind only counts on the final byte; scramble it elsewhere.
            b.kind  = b.tail ? kind : 3'($urandom_range(MODE_STATUS, MODE_SPARE7));
            b.typed = typed && b.tail;
            b.want  = want;
            rx_beats.push_back(b);
        end
    endfunction

    // Sender: build all stimulus, reset, then offer beats with random gaps.
    initial begin
        int         rand_bytes;
        int         rand_results;
        int         pick;
        int         n;
        int         gap;
        bit         tx_calm;
        logic [2:0] m;
        t_rx_beat   b;

        i_rst_n             <= 1'b0;
        byte_bus.valid      <= 1'b0;
        byte_bus.rx_byte    <= '0;
        byte_bus.mode       <= '0;
        byte_bus.last_byte  <= 1'b0;
        model_crc    = CRC_INIT;
        model_count  = '0;
        mismatches   = 0;
        results_seen = 0;
        tx_calm      = 1'b0;

        foreach (frame_table[i]) begin
            queue_frame(frame_table[i].kind, frame_table[i].nbytes, frame_table[i].fill,
                        frame_table[i].crc_good, frame_table[i].typed,
                        '{frame_table[i].want_status, 2'd0, frame_table[i].want_value, 1'b1});
        end

        // Random frames: mostly well formed with random content, the rest
        // broken CRCs, random lengths and kinds, and the odd long frame.
        rand_bytes   = 0;
        rand_results = 0;
        while (rand_bytes < RANDOM_BYTES || rand_results < RANDOM_RESULTS) begin
            pick = $urandom_range(0, 19);
            m    = 3'($urandom_range(MODE_STATUS, MODE_FOUR4));
            if (pick < 15) begin
                n = frame_len(m);
                queue_frame(m, n, FILL_RAND, 1'b1, 1'b0, '0);
                rand_results += values_in(m);
            end else if (pick < 17) begin
                n = frame_len(m);
                queue_frame(m, n, FILL_RAND, 1'b0, 1'b0, '0);
                rand_results += 1;
            end else if (pick < 19) begin
                m = 3'($urandom_range(MODE_STATUS, MODE_SPARE7));
                n = $urandom_range(1, 24);
                queue_frame(m, n, FILL_RAND, 1'($urandom_range(0, 1)), 1'b0, '0);
                rand_results += 1;
            end else begin
                n = $urandom_range(FRAME_BYTES + 1, 64);
                queue_frame(m, n, FILL_RAND, 1'b1, 1'b0, '0);
                rand_results += 1;
            end
            rand_bytes += n;
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rx_beats[i]) begin
            b = rx_beats[i];
            // Switch between gapped and back-to-back stretches now and then.
            if (i % 32 == 0) begin
                tx_calm = ($urandom_range(0, 3) == 0);
            end
            gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                byte_bus.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            byte_bus.valid     <= 1'b1;
            byte_bus.rx_byte   <= b.data;
            byte_bus.mode      <= b.kind;
            byte_bus.last_byte <= b.tail;
            do @(posedge i_clk); while (!byte_bus.ready);
            decode_beat(b.data, b.kind, b.tail);
            if (b.typed) begin
                pending_results.push_back(b.want);
            end else begin
                foreach (frame_results[k]) begin
                    pending_results.push_back(frame_results[k]);
                end
            end
        end
        byte_bus.valid <= 1'b0;

        // Drain, then give stray results a chance to show up.
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Receiver: stall at random before each beat; hold off once for a long
    // stretch so the block fills up and pushes back on the byte side.
    initial begin
        int stall;
        bit held;
        bit rx_calm;
        result_bus.ready <= 1'b0;
        held    = 1'b0;
        rx_calm = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (results_seen % 16 == 0) begin
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            stall = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
            if (!held && results_seen >= 20) begin
                held  = 1'b1;
                stall = HOLD_OFF;
            end
            if (stall > 0) begin
                result_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            result_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!result_bus.valid);
        end
    end

    // Compare each accepted result beat with the oldest expectation.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && result_bus.valid && result_bus.ready) begin
            got = '{t_status'(result_bus.status), result_bus.value_index, result_bus.value,
                    result_bus.last_value};
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result status=%0d index=%0d value=%h last=%0b",
                         $time, got.status, got.slot, got.value, got.last_value);
            end else begin
                want = pending_results.pop_front();
                if (got.status != want.status || got.slot != want.slot ||
                    got.value != want.value || got.last_value != want.last_value) begin
                    mismatches++;
                    $display("%0t: expected status=%0d index=%0d value=%h last=%0b, got %0d %0d %h %0b",
                             $time, want.status, want.slot, want.value, want.last_value,
                             got.status, got.slot, got.value, got.last_value);
                end
            end
        end
    end

    // Watchdog: end a hung run.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

endmodule

### files.f
rtl/mrfc_pkg.sv
rtl/mrfc_if.sv
rtl/meter_response_frame_checker.sv
tb/sv/meter_response_frame_checker_tb.sv
